// ===== rtl/rhp_pkg.sv =====
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared beat type and the degree sine function for the RGB to HSI pixel pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package rhp_pkg;

    localparam int NUM_CELLS = 59;
    localparam int QUO_BITS  = 7;

    // pi in Q60
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // one degree in Q60
    localparam logic [63:0] STEP_Q60 = PI_Q60 / 64'd180;

    // ceil(2^32 * 100 / 765), exact for sum <= 765
    localparam logic [29:0] INTEN_MULT = 30'd561433634;

    typedef struct packed {
        logic        vld;
        logic [7:0]  a;
        logic [7:0]  c;
        logic [5:0]  cnt;
        logic [8:0]  base;
        logic        mirror;
        logic        sat_en;
        logic        hue_en;
        logic [16:0] rem;
        logic [9:0]  div;
        logic [6:0]  quo;
        logic [6:0]  inten;
    } t_beat;

    // (x*y) >> 60, truncated to 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[123:60];
    endfunction

    // quotient by long division
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, dv}) begin
                r    = r - {1'b0, dv};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(d degrees) in Q52 by a Taylor series in Q60
    function automatic logic [51:0] sin_q52(input int d);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] den;
        logic [63:0] rnd;
        x    = STEP_Q60 * 64'(d);
        x2   = mul_q60(x, x);
        term = x;
        acc  = x;
        for (int k = 1; k < 30; k++) begin
            if (term != 64'd0) begin
                den  = 64'((2 * k) * (2 * k + 1));
                term = udiv64(mul_q60(term, x2), den);
                if ((k & 1) == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
        end
        rnd = (acc + 64'd128) >> 8;
        return rnd[51:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsi_pixel_top.sv =====
// pipeline: an input beat passes 2 front stages, 59 degree cells and 1 output
// register on its way to the output beat
// throughput: one pixel per cycle while the skid is empty; a one-entry skid
// behind the output register decouples o_stall from i_stall
// reset: synchronous active-low i_rst_n clears all valid bits; no clearing pass
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel_top
// Geometric RGB to HSI conversion, one 8-bit pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsi_pixel_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [8:0]      o_hue_degrees,
    output logic [6:0]      o_saturation_pct,
    output logic [6:0]      o_intensity_pct
);

    localparam int N = rhp_pkg::NUM_CELLS;

    rhp_pkg::t_beat w_chain [0:N];

    logic       w_adv;
    logic       w_take;
    logic [6:0] w_f;
    logic       w_whole;
    logic [8:0] n_hue;

    logic       r_out_v;
    logic [8:0] r_hue;
    logic [6:0] r_sat;
    logic [6:0] r_int;
    logic       r_skid_v;
    logic [8:0] r_skid_hue;
    logic [6:0] r_skid_sat;
    logic [6:0] r_skid_int;

    assign w_adv  = !r_skid_v;
    assign w_take = r_out_v && !i_stall;

    rhp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_beat  (w_chain[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_cell
        rhp_cell #(.D(k + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_beat  (w_chain[k]),
            .o_beat  (w_chain[k + 1])
        );
    end

    // a zero gap to the top channel means the full 60 degrees
    assign w_f     = 7'(w_chain[N].cnt) + 7'(w_chain[N].a == 8'd0);
    assign w_whole = (w_chain[N].a == 8'd0) || (w_chain[N].c == 8'd0)
                   || (w_chain[N].a == w_chain[N].c);

    always_comb begin
        if (!w_chain[N].hue_en) begin
            n_hue = 9'd0;
        end else if (w_chain[N].mirror) begin
            n_hue = w_chain[N].base - 9'(w_f) - 9'(!w_whole);
        end else begin
            n_hue = w_chain[N].base + 9'(w_f);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (w_take || !r_out_v) begin
                    r_out_v  <= 1'b1;
                    r_hue    <= r_skid_hue;
                    r_sat    <= r_skid_sat;
                    r_int    <= r_skid_int;
                    r_skid_v <= 1'b0;
                end
            end else if (w_chain[N].vld) begin
                if (w_take || !r_out_v) begin
                    r_out_v <= 1'b1;
                    r_hue   <= n_hue;
                    r_sat   <= w_chain[N].sat_en ? w_chain[N].quo : 7'd0;
                    r_int   <= w_chain[N].inten;
                end else begin
                    r_skid_v   <= 1'b1;
                    r_skid_hue <= n_hue;
                    r_skid_sat <= w_chain[N].sat_en ? w_chain[N].quo : 7'd0;
                    r_skid_int <= w_chain[N].inten;
                end
            end else if (w_take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_stall          = r_skid_v;
    assign o_valid          = r_out_v;
    assign o_hue_degrees    = r_hue;
    assign o_saturation_pct = r_sat;
    assign o_intensity_pct  = r_int;

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_hue < 9'd360))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_sat <= 7'd100 && r_int <= 7'd100))
        else $error("percentage out of range");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid full with empty output register");

    a_hue_needs_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_hue != 9'd0) |-> (r_sat != 7'd0))
        else $error("hue without saturation");

endmodule

`default_nettype wire

// ===== rtl/rhp_front.sv =====
// ----------------------------------------------------------------------------
// rhp_front
// Two register stages: channel order, sector gaps, intensity and the
// saturation dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_red,
    input  wire logic [7:0]    i_green,
    input  wire logic [7:0]    i_blue,
    output rhp_pkg::t_beat     o_beat
);

    logic       r_vld1;
    logic [9:0] r_sum;
    logic [7:0] r_mn;
    logic       r_gray;
    logic [7:0] r_a;
    logic [7:0] r_c;
    logic [8:0] r_base;
    logic       r_mirror;

    logic [9:0] n_sum;
    logic [7:0] n_mn;
    logic [7:0] n_mx;
    logic [7:0] n_a;
    logic [7:0] n_c;
    logic [8:0] n_base;
    logic       n_mirror;

    rhp_pkg::t_beat r_beat;
    rhp_pkg::t_beat n_beat;

    logic [9:0]  w_chroma;
    logic [16:0] w_num;
    logic [39:0] w_iprod;

    always_comb begin
        n_sum = 10'(i_red) + 10'(i_green) + 10'(i_blue);
        n_mn  = (i_red < i_green) ? i_red : i_green;
        n_mx  = (i_red > i_green) ? i_red : i_green;
        n_mn  = (n_mn < i_blue) ? n_mn : i_blue;
        n_mx  = (n_mx > i_blue) ? n_mx : i_blue;
        priority if (i_red >= i_green && i_green >= i_blue) begin
            n_a = i_red - i_green;   n_c = i_green - i_blue;
            n_base = 9'd0;   n_mirror = 1'b0;
        end else if (i_green >= i_red && i_red >= i_blue) begin
            n_a = i_green - i_red;   n_c = i_red - i_blue;
            n_base = 9'd120; n_mirror = 1'b1;
        end else if (i_green >= i_blue && i_blue >= i_red) begin
            n_a = i_green - i_blue;  n_c = i_blue - i_red;
            n_base = 9'd120; n_mirror = 1'b0;
        end else if (i_blue >= i_green && i_green >= i_red) begin
            n_a = i_blue - i_green;  n_c = i_green - i_red;
            n_base = 9'd240; n_mirror = 1'b1;
        end else if (i_blue >= i_red && i_red >= i_green) begin
            n_a = i_blue - i_red;    n_c = i_red - i_green;
            n_base = 9'd240; n_mirror = 1'b0;
        end else begin
            n_a = i_red - i_blue;    n_c = i_blue - i_green;
            n_base = 9'd360; n_mirror = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_adv) begin
            r_vld1   <= i_valid;
            r_sum    <= n_sum;
            r_mn     <= n_mn;
            r_gray   <= (n_mx == n_mn);
            r_a      <= n_a;
            r_c      <= n_c;
            r_base   <= n_base;
            r_mirror <= n_mirror;
        end
    end

    // intensity: sum * 100 / 765 via reciprocal multiply
    assign w_chroma = r_sum - 10'(3 * r_mn);
    assign w_num    = 17'(w_chroma) * 17'd100;
    assign w_iprod  = 40'(r_sum) * 40'(rhp_pkg::INTEN_MULT);

    always_comb begin
        n_beat        = '0;
        n_beat.vld    = r_vld1;
        n_beat.a      = r_a;
        n_beat.c      = r_c;
        n_beat.base   = r_base;
        n_beat.mirror = r_mirror;
        n_beat.sat_en = (r_sum != 10'd0) && !r_gray;
        n_beat.hue_en = n_beat.sat_en && (w_num > 17'(r_sum));
        n_beat.rem    = w_num;
        n_beat.div    = r_sum;
        n_beat.inten  = w_iprod[38:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
        end else if (i_adv) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

// ===== rtl/rhp_cell.sv =====
// ----------------------------------------------------------------------------
// rhp_cell
// One degree of the hue search; the first cells also retire one quotient bit
// of the saturation divide.
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_cell #(
    parameter int D = 1
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_adv,
    input  rhp_pkg::t_beat i_beat,
    output rhp_pkg::t_beat o_beat
);

    localparam logic [51:0] S_LO   = rhp_pkg::sin_q52(D);
    localparam logic [51:0] S_HI   = rhp_pkg::sin_q52(60 - D);
    localparam int          QBIT   = rhp_pkg::QUO_BITS - D;
    localparam bit          DIV_EN = (QBIT >= 0);
    localparam int          QPOS   = DIV_EN ? QBIT : 0;

    logic [59:0]    w_lhs;
    logic [59:0]    w_rhs;
    rhp_pkg::t_beat n_beat;
    rhp_pkg::t_beat r_beat;

    assign w_lhs = 60'(i_beat.c) * 60'(S_HI);
    assign w_rhs = 60'(i_beat.a) * 60'(S_LO);

    always_comb begin
        n_beat = i_beat;
        if (w_lhs >= w_rhs) begin
            n_beat.cnt = i_beat.cnt + 6'd1;
        end
        if (DIV_EN) begin
            // restoring divide step
            if (i_beat.rem >= (17'(i_beat.div) << QPOS)) begin
                n_beat.rem       = i_beat.rem - (17'(i_beat.div) << QPOS);
                n_beat.quo[QPOS] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
        end else if (i_adv) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

// ===== bench/rgb_hsi_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_hsi_checker
// Watches both channels of the RGB to HSI pipe. It predicts the hue,
// saturation and intensity of every accepted pixel and checks each result
// beat, in order, against that prediction.
// ----------------------------------------------------------------------------

module rgb_hsi_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       o_stall,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    input  wire logic       o_valid,
    input  wire logic       i_stall,
    input  wire logic [8:0] o_hue_degrees,
    input  wire logic [6:0] o_saturation_pct,
    input  wire logic [6:0] o_intensity_pct,
    output int              fail_count,
    output int              hsi_pending,
    output int              hsi_checked
);

    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] inten;
    } t_hsi;

    localparam logic [63:0] PI_FIX60 = 64'h3243F6A8885A308D;

    t_hsi        hsi_q[$];
    logic [51:0] deg_sine [0:60];

    function automatic logic [63:0] fix60_mul(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[123:60];
    endfunction

    initial begin
        logic [63:0] ang;
        logic [63:0] ang2;
        logic [63:0] term;
        logic [63:0] acc;
        for (int d = 0; d <= 60; d++) begin
            ang  = (PI_FIX60 / 64'd180) * 64'(d);
            ang2 = fix60_mul(ang, ang);
            term = ang;
            acc  = ang;
            for (int k = 1; k < 30 && term != 64'd0; k++) begin
                term = fix60_mul(term, ang2) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            acc = (acc + 64'd128) >> 8;
            deg_sine[d] = acc[51:0];
        end
    end

    // floor of the angle inside a sector, from the two channel gaps
    function automatic int sector_angle(input int gap_hi, input int gap_lo, output bit exact);
        int n;
        logic [63:0] lhs;
        logic [63:0] rhs;
        n = 0;
        for (int d = 1; d < 60; d++) begin
            lhs = 64'(gap_lo) * 64'(deg_sine[60 - d]);
            rhs = 64'(gap_hi) * 64'(deg_sine[d]);
            if (lhs >= rhs) n++;
        end
        if (gap_hi == 0) n++;
        exact = (gap_hi == 0) || (gap_lo == 0) || (gap_hi == gap_lo);
        return n;
    endfunction

    function automatic t_hsi hsi_of(input logic [7:0] rr, input logic [7:0] gg,
                                    input logic [7:0] bb);
        int r, g, b, sum, lo, hi, chroma, hue, f;
        bit exact;
        t_hsi res;
        r = rr; g = gg; b = bb;
        sum = r + g + b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        hue = 0;
        res.sat = '0;
        res.inten = 7'((100 * sum) / 765);
        if (sum != 0 && hi != lo) begin
            chroma = sum - 3 * lo;
            res.sat = 7'((100 * chroma) / sum);
            // weak saturation leaves hue at zero
            if (100 * chroma > sum) begin
                if (r >= g && g >= b) begin
                    hue = sector_angle(r - g, g - b, exact);
                end else if (g >= r && r >= b) begin
                    f = sector_angle(g - r, r - b, exact);
                    hue = exact ? 120 - f : 119 - f;
                end else if (g >= b && b >= r) begin
                    hue = 120 + sector_angle(g - b, b - r, exact);
                end else if (b >= g && g >= r) begin
                    f = sector_angle(b - g, g - r, exact);
                    hue = exact ? 240 - f : 239 - f;
                end else if (b >= r && r >= g) begin
                    hue = 240 + sector_angle(b - r, r - g, exact);
                end else begin
                    f = sector_angle(r - b, b - g, exact);
                    hue = exact ? 360 - f : 359 - f;
                end
            end
        end
        res.hue = 9'(hue);
        return res;
    endfunction

    initial begin
        fail_count  = 0;
        hsi_checked = 0;
        hsi_pending = 0;
    end

    always @(posedge i_clk) begin
        t_hsi want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                hsi_q.push_back(hsi_of(i_red, i_green, i_blue));
            end
            if (o_valid && !i_stall) begin
                if (hsi_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: hue %0d sat %0d int %0d",
                             $time, o_hue_degrees, o_saturation_pct, o_intensity_pct);
                    fail_count++;
                end else begin
                    want = hsi_q.pop_front();
                    hsi_checked++;
                    if (o_hue_degrees !== want.hue) begin
                        $display("%0t: hue mismatch: expected %0d actual %0d",
                                 $time, want.hue, o_hue_degrees);
                        fail_count++;
                    end
                    if (o_saturation_pct !== want.sat) begin
                        $display("%0t: saturation mismatch: expected %0d actual %0d",
                                 $time, want.sat, o_saturation_pct);
                        fail_count++;
                    end
                    if (o_intensity_pct !== want.inten) begin
                        $display("%0t: intensity mismatch: expected %0d actual %0d",
                                 $time, want.inten, o_intensity_pct);
                        fail_count++;
                    end
                end
            end
            hsi_pending = hsi_q.size();
        end
    end

endmodule

// ===== bench/rgb_to_hsi_pixel_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel_top_tb
// Drives directed and random pixels into the RGB to HSI pipe with bursty
// input and random output back-pressure; the checker judges every result.
// ----------------------------------------------------------------------------

module rgb_to_hsi_pixel_top_tb;

    localparam int NUM_RANDOM  = 1380;
    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 80;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_red;
    logic [7:0] i_green;
    logic [7:0] i_blue;
    logic       o_valid;
    logic       i_stall;
    logic [8:0] o_hue_degrees;
    logic [6:0] o_saturation_pct;
    logic [6:0] o_intensity_pct;

    int fail_count;
    int hsi_pending;
    int hsi_checked;
    int pixels_sent;
    int idle_cycles;
    int stall_mode;
    int cyc;

    rgb_to_hsi_pixel_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hue_degrees    (o_hue_degrees),
        .o_saturation_pct (o_saturation_pct),
        .o_intensity_pct  (o_intensity_pct)
    );

    rgb_hsi_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hue_degrees    (o_hue_degrees),
        .o_saturation_pct (o_saturation_pct),
        .o_intensity_pct  (o_intensity_pct),
        .fail_count       (fail_count),
        .hsi_pending      (hsi_pending),
        .hsi_checked      (hsi_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_red   = '0;
        i_green = '0;
        i_blue  = '0;
        i_stall = 1'b0;
    end

    // receiver back-pressure: stall_mode picks one of four patterns and is redrawn at random
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc % 250 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 99) < 30);
            end
            2: begin
                i_stall <= ($urandom_range(0, 99) < 75);
            end
            default: begin
                i_stall <= ((cyc % 7) < 3);
            end
        endcase
    end

    initial begin
        cyc = 0;
        stall_mode = 0;
    end

    // watchdog on cycles where neither channel moves a beat
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d quiet cycles", IDLE_LIMIT);
            $display("rgb_to_hsi_pixel_top regression: fail");
            $finish;
        end
    end

    initial idle_cycles = 0;

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pixels_sent++;
    endtask

    task automatic pause_input(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic random_pixel();
        logic [7:0] base;
        int kind;
        kind = $urandom_range(0, 9);
        base = 8'($urandom);
        if (kind < 5) begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end else if (kind < 7) begin
            // near gray, around the weak saturation edge
            send_pixel(8'(base + $urandom_range(0, 3)), 8'(base + $urandom_range(0, 3)),
                       8'(base + $urandom_range(0, 3)));
        end else if (kind < 9) begin
            // equal gaps and repeated channels give whole sector angles
            case ($urandom_range(0, 5))
                0: send_pixel(base, base, 8'($urandom));
                1: send_pixel(base, 8'($urandom), base);
                2: send_pixel(8'($urandom), base, base);
                3: send_pixel(8'(base >> 1), base, 8'd0);
                4: send_pixel(8'd0, 8'(base >> 1), base);
                default: send_pixel(base, 8'd0, 8'(base >> 1));
            endcase
        end else begin
            send_pixel({$urandom_range(0, 1) ? 8'hff : 8'h00},
                       {$urandom_range(0, 1) ? 8'hff : 8'h00}, 8'($urandom));
        end
    endtask

    initial begin
        int burst;
        pixels_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // black, white, primaries and secondaries
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        // gray and weak saturation
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd100, 8'd100, 8'd101);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd254, 8'd255, 8'd255);
        // one pixel in every sector, then equal gaps
        send_pixel(8'd200, 8'd150, 8'd0);
        send_pixel(8'd150, 8'd200, 8'd0);
        send_pixel(8'd0, 8'd200, 8'd150);
        send_pixel(8'd0, 8'd150, 8'd200);
        send_pixel(8'd150, 8'd0, 8'd200);
        send_pixel(8'd200, 8'd0, 8'd150);
        send_pixel(8'd200, 8'd100, 8'd0);
        send_pixel(8'd100, 8'd200, 8'd0);
        send_pixel(8'd0, 8'd100, 8'd200);
        send_pixel(8'd200, 8'd0, 8'd100);
        pause_input(3);

        while (pixels_sent < NUM_RANDOM + 22) begin
            burst = $urandom_range(1, 40);
            repeat (burst) random_pixel();
            pause_input($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
        end
        i_valid <= 1'b0;

        while (hsi_pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d pixels (directed corners, sectors, near gray, random), checked %0d",
                 pixels_sent, hsi_checked);
        $display("input in random bursts, output under four back-pressure patterns");
        if (fail_count == 0) begin
            $display("rgb_to_hsi_pixel_top regression: pass");
        end else begin
            $display("rgb_to_hsi_pixel_top regression: fail");
        end
        $finish;
    end

endmodule
